// ===== rtl/cal_pkg.sv =====
// Package for the checked 64-bit integer ALU: transfer structs, lane and
// side-band types, operation and status codes. No dependencies.
`default_nettype none
package cal_pkg;

	localparam int unsigned Width = 64;
	localparam int unsigned Steps = Width;

	// operation codes
	localparam logic [3:0] OP_OR  = 4'd0;
	localparam logic [3:0] OP_XOR = 4'd1;
	localparam logic [3:0] OP_AND = 4'd2;
	localparam logic [3:0] OP_EQ  = 4'd3;
	localparam logic [3:0] OP_NE  = 4'd4;
	localparam logic [3:0] OP_LT  = 4'd5;
	localparam logic [3:0] OP_GT  = 4'd6;
	localparam logic [3:0] OP_LE  = 4'd7;
	localparam logic [3:0] OP_GE  = 4'd8;
	localparam logic [3:0] OP_ADD = 4'd9;
	localparam logic [3:0] OP_SUB = 4'd10;
	localparam logic [3:0] OP_MUL = 4'd11;
	localparam logic [3:0] OP_DIV = 4'd12;
	localparam logic [3:0] OP_MOD = 4'd13;
	localparam logic [3:0] OP_NEG = 4'd14;
	localparam logic [3:0] OP_NOT = 4'd15;

	// view status codes
	localparam logic [1:0] ST_UNDEF = 2'd0;
	localparam logic [1:0] ST_VALID = 2'd1;
	localparam logic [1:0] ST_OVFL  = 2'd2;

	localparam logic [Width-1:0] SignBit = {1'b1, {(Width-1){1'b0}}};
	localparam logic [Width-1:0] AllOnes = {Width{1'b1}};

	typedef struct packed {
		logic [3:0]       operation;
		logic [Width-1:0] left_bits;
		logic [Width-1:0] right_bits;
		logic             left_signed_ok;
		logic             left_unsigned_ok;
		logic             right_signed_ok;
		logic             right_unsigned_ok;
		logic             left_truth;
		logic             right_truth;
		logic             left_truth_ok;
		logic             right_truth_ok;
	} in_t;

	typedef struct packed {
		logic [1:0]              signed_status;
		logic signed [Width-1:0] signed_result;
		logic [1:0]              unsigned_status;
		logic [Width-1:0]        unsigned_result;
		logic [1:0]              truth_status;
		logic                    truth_result;
	} out_t;

	// one shift-add / shift-subtract lane
	typedef struct packed {
		logic [2*Width-1:0] acc;
		logic [Width-1:0]   x;
		logic [Width-1:0]   y;
	} lane_t;

	// item data that rides along the cell chain
	typedef struct packed {
		logic [3:0] op;
		out_t       pre;
		logic       mul_mode;
		logic       both_u;
		logic       both_s;
		logic       ru_zero;
		logic       rs_zero;
		logic       min_m1;
		logic       neg;
		logic       a_sign;
	} side_t;

endpackage
`default_nettype wire

// ===== rtl/cal_front.sv =====
// Front decode of the checked ALU: results of the operations other than multiply, divide and modulo,
// lane setup for multiply and divide. Depends on cal_pkg.
`default_nettype none
module cal_front (
	input  cal_pkg::in_t   d,
	output cal_pkg::lane_t u_lane,
	output cal_pkg::lane_t s_lane,
	output cal_pkg::side_t side
);
	import cal_pkg::*;

	logic [Width-1:0] a, b, ma, mb, sum, dif, negv;
	logic bs, bu, bt, cmp_t, cmp_u, cmp_s;
	out_t pre;

	function automatic logic cmp(input logic [3:0] op, input logic [Width-1:0] p,
		input logic [Width-1:0] q);
		logic r;
		case (op)
			OP_EQ:   r = (p == q);
			OP_NE:   r = (p != q);
			OP_LT:   r = (p < q);
			OP_GT:   r = (p > q);
			OP_LE:   r = (p <= q);
			default: r = (p >= q);
		endcase
		return r;
	endfunction

	assign a    = d.left_bits;
	assign b    = d.right_bits;
	assign ma   = a[Width-1] ? (Width'(0) - a) : a;
	assign mb   = b[Width-1] ? (Width'(0) - b) : b;
	assign sum  = a + b;
	assign dif  = a - b;
	assign negv = Width'(0) - a;
	assign bs   = d.left_signed_ok & d.right_signed_ok;
	assign bu   = d.left_unsigned_ok & d.right_unsigned_ok;
	assign bt   = d.left_truth_ok & d.right_truth_ok;

	assign cmp_t = cmp(d.operation, {{(Width-1){1'b0}}, d.left_truth},
		{{(Width-1){1'b0}}, d.right_truth});
	assign cmp_u = cmp(d.operation, a, b);
	assign cmp_s = cmp(d.operation, a ^ SignBit, b ^ SignBit);

	// results of everything except multiply, divide and modulo
	always_comb begin
		pre = '0;
		case (d.operation) inside
			OP_OR, OP_XOR, OP_AND: begin
				if (bt) begin
					pre.truth_status = ST_VALID;
					pre.truth_result = (d.operation == OP_OR) ? (d.left_truth | d.right_truth) :
						(d.operation == OP_XOR) ? (d.left_truth ^ d.right_truth) :
						(d.left_truth & d.right_truth);
				end
				if (bu) begin
					pre.unsigned_status = ST_VALID;
					pre.unsigned_result = (d.operation == OP_OR) ? (a | b) :
						(d.operation == OP_XOR) ? (a ^ b) : (a & b);
				end
			end
			[OP_EQ:OP_GE]: begin
				// last valid view wins
				if (bt) begin
					pre.truth_status = ST_VALID;
					pre.truth_result = cmp_t;
				end
				if (bu) begin
					pre.truth_status = ST_VALID;
					pre.truth_result = cmp_u;
				end
				if (bs) begin
					pre.truth_status = ST_VALID;
					pre.truth_result = cmp_s;
				end
			end
			OP_ADD: begin
				if (bu) begin
					pre.unsigned_result = sum;
					pre.unsigned_status = (sum < a) ? ST_OVFL : ST_VALID;
				end
				if (bs) begin
					pre.signed_result = sum;
					pre.signed_status = ((a[Width-1] ^ sum[Width-1]) & (b[Width-1] ^ sum[Width-1]))
						? ST_OVFL : ST_VALID;
				end
			end
			OP_SUB: begin
				if (bu) begin
					pre.unsigned_result = dif;
					pre.unsigned_status = (b > a) ? ST_OVFL : ST_VALID;
				end
				if (bs) begin
					pre.signed_result = dif;
					pre.signed_status = ((a[Width-1] ^ b[Width-1]) & (a[Width-1] ^ dif[Width-1]))
						? ST_OVFL : ST_VALID;
				end
			end
			OP_NEG: begin
				if (d.left_signed_ok) begin
					pre.signed_result = negv;
					pre.signed_status = (a == SignBit) ? ST_OVFL : ST_VALID;
				end
				// unsigned 2^63 negates to a valid most negative value
				if (d.left_unsigned_ok && a == SignBit) begin
					pre.signed_result = SignBit;
					pre.signed_status = ST_VALID;
				end
			end
			OP_NOT: begin
				if (d.left_truth_ok) begin
					pre.truth_status = ST_VALID;
					pre.truth_result = ~d.left_truth;
				end
				if (d.left_unsigned_ok) begin
					pre.unsigned_status = ST_VALID;
					pre.unsigned_result = ~a;
				end
			end
			default: pre = '0;
		endcase
		if (pre.signed_status != ST_VALID) pre.signed_result = '0;
		if (pre.unsigned_status != ST_VALID) pre.unsigned_result = '0;
		if (pre.truth_status != ST_VALID) pre.truth_result = 1'b0;
	end

	// lane setup: multiply accumulates from zero, divide starts with the dividend
	always_comb begin
		u_lane = '0;
		s_lane = '0;
		u_lane.x = (d.operation == OP_MUL) ? a : b;
		s_lane.x = (d.operation == OP_MUL) ? ma : mb;
		u_lane.y = b;
		s_lane.y = mb;
		if (d.operation != OP_MUL) begin
			u_lane.acc = {{Width{1'b0}}, a};
			s_lane.acc = {{Width{1'b0}}, ma};
		end
	end

	assign side.op       = d.operation;
	assign side.pre      = pre;
	assign side.mul_mode = (d.operation == OP_MUL);
	assign side.both_u   = bu;
	assign side.both_s   = bs;
	assign side.ru_zero  = d.right_unsigned_ok && (b == '0);
	assign side.rs_zero  = d.right_signed_ok && (b == '0);
	assign side.min_m1   = (a == SignBit) && (b == AllOnes);
	assign side.neg      = a[Width-1] ^ b[Width-1];
	assign side.a_sign   = a[Width-1];

endmodule
`default_nettype wire

// ===== rtl/cal_cell.sv =====
// One cell of the multiply/divide chain: one shift-add or restoring
// shift-subtract step on the unsigned and magnitude lanes. Depends on cal_pkg.
`default_nettype none
module cal_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_i,
	input  cal_pkg::lane_t u_i,
	input  cal_pkg::lane_t s_i,
	input  cal_pkg::side_t side_i,
	output logic           valid_o,
	output cal_pkg::lane_t u_o,
	output cal_pkg::lane_t s_o,
	output cal_pkg::side_t side_o
);
	import cal_pkg::*;

	logic  valid_s1;
	lane_t u_s1, s_s1, u_nx, s_nx;
	side_t side_s1;

	function automatic lane_t step(input lane_t l, input logic mul);
		lane_t r;
		logic [Width:0]   rem;
		logic [Width+1:0] t;
		r   = l;
		rem = l.acc[2*Width-1:Width-1];
		t   = {1'b0, rem} - {2'b00, l.x};
		if (mul) begin
			// MSB-first shift-add
			r.acc = {l.acc[2*Width-2:0], 1'b0} +
				{{Width{1'b0}}, (l.y[Width-1] ? l.x : {Width{1'b0}})};
			r.y = {l.y[Width-2:0], 1'b0};
		end else if (!t[Width+1]) begin
			r.acc = {t[Width-1:0], l.acc[Width-2:0], 1'b1};
		end else begin
			r.acc = {l.acc[2*Width-2:0], 1'b0};
		end
		return r;
	endfunction

	assign u_nx = step(u_i, side_i.mul_mode);
	assign s_nx = step(s_i, side_i.mul_mode);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= u_nx;
			s_s1    <= s_nx;
			side_s1 <= side_i;
		end
	end

	assign valid_o = valid_s1;
	assign u_o     = u_s1;
	assign s_o     = s_s1;
	assign side_o  = side_s1;

endmodule
`default_nettype wire

// ===== rtl/cal_back.sv =====
// Result assembly of the checked ALU: overflow tests and signs for multiply,
// divide and modulo; other operations pass through. Depends on cal_pkg.
`default_nettype none
module cal_back (
	input  cal_pkg::lane_t u_lane,
	input  cal_pkg::lane_t s_lane,
	input  cal_pkg::side_t side,
	output cal_pkg::out_t  res
);
	import cal_pkg::*;

	logic [Width-1:0] p_lo, q_s, r_s;

	assign p_lo = s_lane.acc[Width-1:0];
	assign q_s  = s_lane.acc[Width-1:0];
	assign r_s  = s_lane.acc[2*Width-1:Width];

	always_comb begin
		res = side.pre;
		case (side.op)
			OP_MUL: begin
				if (side.both_u) begin
					res.unsigned_result = u_lane.acc[Width-1:0];
					res.unsigned_status = (|u_lane.acc[2*Width-1:Width]) ? ST_OVFL : ST_VALID;
				end
				if (side.both_s) begin
					res.signed_result = side.neg ? (Width'(0) - p_lo) : p_lo;
					// magnitude must stay within 2^63 (negative) or 2^63-1
					res.signed_status = ((|s_lane.acc[2*Width-1:Width]) ||
						(side.neg ? (p_lo > SignBit) : p_lo[Width-1])) ? ST_OVFL : ST_VALID;
				end
			end
			OP_DIV: begin
				if (side.ru_zero) begin
					res.unsigned_status = ST_OVFL;
				end else if (side.both_u) begin
					res.unsigned_status = ST_VALID;
					res.unsigned_result = u_lane.acc[Width-1:0];
				end
				if (side.rs_zero) begin
					res.signed_status = ST_OVFL;
				end else if (side.both_s) begin
					if (side.min_m1) begin
						res.signed_status = ST_OVFL;
					end else begin
						res.signed_status = ST_VALID;
						res.signed_result = side.neg ? (Width'(0) - q_s) : q_s;
					end
				end
			end
			OP_MOD: begin
				if (side.ru_zero) begin
					res.unsigned_status = ST_VALID;
				end else if (side.both_u) begin
					res.unsigned_status = ST_VALID;
					res.unsigned_result = u_lane.acc[2*Width-1:Width];
				end
				if (side.rs_zero) begin
					res.signed_status = ST_VALID;
				end else if (side.both_s) begin
					if (side.min_m1) begin
						res.signed_status = ST_OVFL;
					end else begin
						res.signed_status = ST_VALID;
						res.signed_result = side.a_sign ? (Width'(0) - r_s) : r_s;
					end
				end
			end
			default: res = side.pre;
		endcase
		if (res.signed_status != ST_VALID) res.signed_result = '0;
		if (res.unsigned_status != ST_VALID) res.unsigned_result = '0;
	end

endmodule
`default_nettype wire

// ===== rtl/checked_integer_alu64_top.sv =====
// Top level of the overflow-checked 64-bit integer ALU: front decode, the
// 64-cell multiply/divide chain, result assembly and output register.
// Depends on cal_pkg, cal_front, cal_cell, cal_back.
//
// One operation is taken per clock while in_stall is low, and results leave in
// order, one per clock while out_stall is low. Every item walks through the
// chain of 64 cells, one multiply or divide bit per cell, and then the output
// register; the whole chain moves forward together and halts only while a
// finished result waits in the output register under stall.
`default_nettype none
module checked_integer_alu64_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  cal_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output cal_pkg::out_t out_data
);
	import cal_pkg::*;

	lane_t u_ch [Steps+1];
	lane_t s_ch [Steps+1];
	side_t side_ch [Steps+1];
	logic  vld_ch [Steps+1];
	logic  en;
	logic  out_valid_q;
	out_t  out_q, res;

	// chain advances unless a result is held under stall
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	cal_front u_front (
		.d      (in_data),
		.u_lane (u_ch[0]),
		.s_lane (s_ch[0]),
		.side   (side_ch[0])
	);
	assign vld_ch[0] = in_valid;

	for (genvar i = 0; i < Steps; i++) begin : g_cell
		cal_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (vld_ch[i]),
			.u_i     (u_ch[i]),
			.s_i     (s_ch[i]),
			.side_i  (side_ch[i]),
			.valid_o (vld_ch[i+1]),
			.u_o     (u_ch[i+1]),
			.s_o     (s_ch[i+1]),
			.side_o  (side_ch[i+1])
		);
	end

	cal_back u_back (
		.u_lane (u_ch[Steps]),
		.s_lane (s_ch[Steps]),
		.side   (side_ch[Steps]),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_ch[Steps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a signed or unsigned view that is not valid always reads as zero
	a_sres_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.signed_status != ST_VALID) |-> out_q.signed_result == '0)
		else $error("signed result nonzero while not valid");
	a_ures_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.unsigned_status != ST_VALID) |-> out_q.unsigned_result == '0)
		else $error("unsigned result nonzero while not valid");
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without a held result");
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_ch[Steps]))
		else $error("chain moved while stalled");

endmodule
`default_nettype wire
